@@ rtl/core/keyed_byte_substitution_cipher_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyed byte substitution cipher unit
// Clocked concurrent checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef KEYED_BYTE_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH
`define KEYED_BYTE_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KBSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define KBSC_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/kbsc_pkg.sv @@
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared constants, codes, types and small functions of the cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kbsc_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int BYTE_W        = 8;
	localparam int KEY_W         = 64;
	localparam int MOD_W         = 16;
	localparam int HALF_W        = KEY_W / 2;
	localparam int NIB_W         = 4;
	localparam int CMD_W         = 2;
	localparam int MODE_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_W         = KEY_W;

	// commands
	localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd2;

	// cipher modes
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STATIC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODIFIER = 2'd2;

	localparam logic [BYTE_W-1:0] BYTE_ZERO = '0;
	localparam logic [BYTE_W-1:0] BYTE_TOP  = BYTE_W'(TABLE_ENTRIES - 1);
	localparam logic [BYTE_W-1:0] STATIC_LAST = BYTE_W'(TABLE_ENTRIES - 2);

	localparam logic [BYTE_W-1:0] LCG_MUL   = 8'd13;
	localparam logic [BYTE_W-1:0] LCG_ADD   = 8'd11;
	localparam logic [BYTE_W-1:0] WALK_STEP = 8'h11;

	localparam logic [NIB_W-1:0] NIB_MUL_BASE = 4'h5;
	localparam logic [NIB_W-1:0] NIB_ADD_MASK = 4'hE;
	localparam logic [NIB_W-1:0] NIB_MASK     = 4'hF;

	// key preparation result
	typedef struct packed {
		logic             done;
		logic [KEY_W-1:0] key;
	} kp_res_t;

	// byte LCG v*13+11 mod 256
	function automatic logic [BYTE_W-1:0] lcg13(logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] t;
		t = v * LCG_MUL + LCG_ADD;
		return t;
	endfunction

	// one step of the seeded nibble LCG
	function automatic logic [NIB_W-1:0] nib_step(logic [NIB_W-1:0] s,
		logic [BYTE_W-1:0] seed);
		logic [NIB_W-1:0]  mul;
		logic [NIB_W-1:0]  add;
		logic [BYTE_W-1:0] p;
		mul = NIB_MUL_BASE | {seed[0], 3'b000};
		add = (seed[NIB_W-1:0] & NIB_ADD_MASK) | 4'h1;
		p = BYTE_W'(s) * BYTE_W'(mul) + BYTE_W'(add);
		return p[NIB_W-1:0] & NIB_MASK;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/kbsc_key_prep.sv @@
// ----------------------------------------------------------------------------
// kbsc_key_prep
// Scrambles the key by the modifier factor (skipped for a zero modifier) and decrements it.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsc_key_prep (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           go,
	input  wire logic [kbsc_pkg::KEY_W-1:0]     key_in,
	input  wire logic [kbsc_pkg::MOD_W-1:0]     modifier,
	output kbsc_pkg::kp_res_t                   res
);

	typedef enum logic [2:0] {
		KP_IDLE,
		KP_MUL_LO,
		KP_MUL_HI,
		KP_SUM,
		KP_DEC
	} kp_state_t;

	kp_state_t                        state_q;
	logic                             done_q;
	logic [kbsc_pkg::KEY_W-1:0]       key_q;
	logic [kbsc_pkg::HALF_W-1:0]      f_q;
	logic [kbsc_pkg::KEY_W-1:0]       prod_q;
	logic [kbsc_pkg::HALF_W-1:0]      hi_q;
	logic [kbsc_pkg::HALF_W-1:0]      f_next;
	logic [kbsc_pkg::MOD_W-1:0]       f_low;
	logic [kbsc_pkg::HALF_W-1:0]      mul_a;
	logic [kbsc_pkg::KEY_W-1:0]       mul_p;

	// factor = (mod << 16) | ((~mod + 2) mod 2^16)
	assign f_low  = ~modifier + kbsc_pkg::MOD_W'(2);
	assign f_next = {modifier, f_low};

	// one shared 32x32 multiplier, low then high key half
	assign mul_a = (state_q == KP_MUL_HI) ? key_q[kbsc_pkg::KEY_W-1:kbsc_pkg::HALF_W]
		: key_q[kbsc_pkg::HALF_W-1:0];
	assign mul_p = kbsc_pkg::KEY_W'(mul_a) * kbsc_pkg::KEY_W'(f_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KP_IDLE;
			done_q  <= 1'b0;
			key_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				KP_IDLE: begin
					if (go) begin
						key_q   <= key_in;
						state_q <= (modifier != '0) ? KP_MUL_LO : KP_DEC;
					end
				end
				KP_MUL_LO: state_q <= KP_MUL_HI;
				KP_MUL_HI: state_q <= KP_SUM;
				KP_SUM: begin
					key_q   <= prod_q + {hi_q, {kbsc_pkg::HALF_W{1'b0}}};
					state_q <= KP_DEC;
				end
				KP_DEC: begin
					key_q   <= key_q - kbsc_pkg::KEY_W'(1);
					done_q  <= 1'b1;
					state_q <= KP_IDLE;
				end
				default: state_q <= KP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == KP_IDLE && go)
			f_q <= f_next;
		if (state_q == KP_MUL_LO)
			prod_q <= mul_p;
		if (state_q == KP_MUL_HI)
			hi_q <= mul_p[kbsc_pkg::HALF_W-1:0];
	end

	assign res.done = done_q;
	assign res.key  = key_q;

endmodule

`default_nettype wire

@@ rtl/core/keyed_byte_substitution_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_byte_substitution_cipher_unit
// Byte substitution through a decrypt table and its inverse, built on command.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands enter on start/command/data_in/last_in; a transfer happens on a
//    clock edge with start high and busy low. Command three is taken and
//    dropped without a result.
//  - Each result sits on data_out/last_out/build_done for one cycle with
//    strobe high. There is no backpressure: the receiver must take it.
//  - Decrypt and encrypt: result in the cycle after the transfer, one byte per
//    cycle sustained (one read of a 256x8 synchronous table each).
//  - Build: busy for the table sweeps, at most one table entry per cycle through
//    the single write port of each memory. Identity and static modes fill the
//    decrypt table; keyed mode runs key prep, grid fill, grid walk, inverse
//    rebuild, and keyed with a zero key builds identity. Spare mode rebuilds only the inverse.
//    The result (build_done, data zero) comes in the first cycle with busy low.
//  - Configuration (cfg_we/cfg_index/cfg_wdata) must be written by the user
//    while idle only; the block does not enforce it. Reset: both tables are
//    swept to identity with busy high; configuration registers clear at once and may be written then.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_byte_substitution_cipher_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output      logic                                busy,
	input  wire logic [kbsc_pkg::CMD_W-1:0]          command,
	input  wire logic [kbsc_pkg::BYTE_W-1:0]         data_in,
	input  wire logic                                last_in,
	// result channel
	output      logic                                strobe,
	output      logic [kbsc_pkg::BYTE_W-1:0]         data_out,
	output      logic                                last_out,
	output      logic                                build_done,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [kbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kbsc_pkg::CFG_W-1:0]          cfg_wdata
);

	typedef enum logic [3:0] {
		ST_CLEAR,       // post-reset identity sweep of both tables
		ST_IDLE,
		ST_KEY,         // waiting on key scramble
		ST_DEC_ID,
		ST_DEC_STATIC,
		ST_GRID,        // keyed grid into the encrypt memory as scratch
		ST_WALK,
		ST_WALK_DRAIN,
		ST_ENDS,        // fixed entries 0 and 255
		ST_ENC_CLR,
		ST_ENC_FILL,
		ST_ENC_DRAIN
	} state_t;

	localparam int AW = kbsc_pkg::ADDR_W;
	localparam int BW = kbsc_pkg::BYTE_W;
	localparam int NW = kbsc_pkg::NIB_W;

	// configuration registers
	logic [kbsc_pkg::MODE_W-1:0] mode_q;
	logic [kbsc_pkg::KEY_W-1:0]  key_q;
	logic [kbsc_pkg::MOD_W-1:0]  mod_q;

	// sequencer state
	state_t          state_q;
	logic [AW-1:0]   cnt_q;
	logic [BW-1:0]   pos_q;      // next decrypt slot during the walk
	logic [BW-1:0]   v_q;        // static LCG value
	logic [BW-1:0]   walk_v_q;   // grid walk position
	logic [NW-1:0]   hs_q;       // high nibble LCG state
	logic [NW-1:0]   ls_q;       // low nibble LCG state
	logic            walk_s1;
	logic            fill_s1;
	logic [BW-1:0]   idx_s1;

	// registered result
	logic            strobe_q;
	logic            build_done_q;
	logic            last_q;
	logic            sel_enc_q;

	// memories
	logic [BW-1:0]   dec_mem [kbsc_pkg::TABLE_ENTRIES];
	logic [BW-1:0]   enc_mem [kbsc_pkg::TABLE_ENTRIES];
	logic [BW-1:0]   dec_rd_q;
	logic [BW-1:0]   enc_rd_q;
	logic            dec_we, enc_we;
	logic [AW-1:0]   dec_wa, enc_wa, dec_ra, enc_ra;
	logic [BW-1:0]   dec_wd, enc_wd;

	// datapath
	logic            accept;
	logic            kp_go;
	kbsc_pkg::kp_res_t kp_res;
	logic [BW-1:0]   static_t;
	logic [BW-1:0]   static_v;
	logic [NW-1:0]   row, col;
	logic [BW-1:0]   mix_sel;
	logic [NW-1:0]   hi_cur, lo_prev, lo_cur;
	logic [BW-1:0]   walk_addr;
	logic            walk_ok;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kbsc_pkg::MODE_NONE;
			key_q  <= '0;
			mod_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kbsc_pkg::REG_MODE:     mode_q <= cfg_wdata[kbsc_pkg::MODE_W-1:0];
				kbsc_pkg::REG_KEY:      key_q  <= cfg_wdata;
				kbsc_pkg::REG_MODIFIER: mod_q  <= cfg_wdata[kbsc_pkg::MOD_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Key scramble and decrement
	// ------------------------------------------------------------------
	assign accept = start && !busy;
	assign kp_go  = accept && (command == kbsc_pkg::CMD_BUILD)
		&& (mode_q == kbsc_pkg::MODE_KEYED) && (key_q != '0);

	kbsc_key_prep u_key_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (kp_go),
		.key_in   (key_q),
		.modifier (mod_q),
		.res      (kp_res)
	);

	// key byte n of the decremented key
	function automatic logic [BW-1:0] kb(logic [kbsc_pkg::KEY_W-1:0] k, int n);
		return k[n*BW +: BW];
	endfunction

	// per-row seed of the low nibble sequence
	function automatic logic [BW-1:0] mix_byte(logic [NW-1:0] r,
		logic [kbsc_pkg::KEY_W-1:0] k);
		logic [BW-1:0] m;
		case (r)
			4'd0:  m = kb(k, 1);
			4'd1:  m = kb(k, 1) ^ kb(k, 6);
			4'd2:  m = kb(k, 2) ^ kb(k, 3);
			4'd3:  m = kb(k, 2);
			4'd4:  m = kb(k, 2) ^ kb(k, 1);
			4'd5:  m = kb(k, 3) ^ kb(k, 4);
			4'd6:  m = kb(k, 3);
			4'd7:  m = kb(k, 3) ^ kb(k, 2);
			4'd8:  m = kb(k, 4) ^ kb(k, 5);
			4'd9:  m = kb(k, 4);
			4'd10: m = kb(k, 4) ^ kb(k, 3);
			4'd11: m = kb(k, 5) ^ kb(k, 6);
			4'd12: m = kb(k, 5);
			4'd13: m = kb(k, 5) ^ kb(k, 4);
			4'd14: m = kb(k, 6) ^ kb(k, 1);
			4'd15: m = kb(k, 6);
			default: m = '0;
		endcase
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Table generators
	// ------------------------------------------------------------------
	// static LCG, stepping over 0 and 255
	assign static_t = kbsc_pkg::lcg13(v_q);
	assign static_v = (static_t == kbsc_pkg::BYTE_ZERO || static_t == kbsc_pkg::BYTE_TOP)
		? kbsc_pkg::lcg13(static_t) : static_t;

	// keyed grid: entry {row,col} = {hi[row], lo_row[col]}
	assign row     = cnt_q[AW-1:NW];
	assign col     = cnt_q[NW-1:0];
	assign mix_sel = mix_byte(row, kp_res.key);

	always_comb begin
		hi_cur  = hs_q;
		lo_prev = ls_q;
		if (col == '0) begin
			hi_cur  = kbsc_pkg::nib_step((row == '0) ? kp_res.key[BW-1:NW] : hs_q,
				kp_res.key[BW-1:0]);
			lo_prev = mix_sel[BW-1:NW];
		end
		lo_cur = kbsc_pkg::nib_step(lo_prev, mix_sel);
	end

	// walk reads grid[v] in the cycle before the decrypt write
	assign walk_addr = walk_v_q + kbsc_pkg::WALK_STEP;
	assign walk_ok   = (enc_rd_q != kbsc_pkg::BYTE_ZERO) && (enc_rd_q != kbsc_pkg::BYTE_TOP)
		&& (pos_q != kbsc_pkg::BYTE_TOP);

	// ------------------------------------------------------------------
	// Memory ports. Reads and writes always target different memories
	// during a sweep, so no forwarding is needed.
	// ------------------------------------------------------------------
	always_comb begin
		dec_we = 1'b0;
		dec_wa = cnt_q;
		dec_wd = cnt_q;
		enc_we = 1'b0;
		enc_wa = cnt_q;
		enc_wd = cnt_q;
		dec_ra = data_in;
		enc_ra = data_in;
		case (state_q)
			ST_CLEAR: begin
				dec_we = 1'b1;
				enc_we = 1'b1;
			end
			ST_DEC_ID:     dec_we = 1'b1;
			ST_DEC_STATIC: begin
				dec_we = 1'b1;
				dec_wd = static_v;
			end
			ST_GRID: begin
				enc_we = 1'b1;
				enc_wd = {hi_cur, lo_cur};
			end
			ST_WALK:       enc_ra = walk_addr;
			ST_ENDS: begin
				dec_we = 1'b1;
				dec_wa = {AW{cnt_q[0]}};
				dec_wd = {BW{cnt_q[0]}};
			end
			ST_ENC_CLR: begin
				enc_we = 1'b1;
				enc_wd = '0;
			end
			ST_ENC_FILL:   dec_ra = cnt_q;
			default: ;
		endcase
		if (walk_s1 && walk_ok) begin
			dec_we = 1'b1;
			dec_wa = pos_q;
			dec_wd = enc_rd_q;
		end
		// inverse: later indexes overwrite earlier ones
		if (fill_s1) begin
			enc_we = 1'b1;
			enc_wa = dec_rd_q;
			enc_wd = idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_we)
			dec_mem[dec_wa] <= dec_wd;
		dec_rd_q <= dec_mem[dec_ra];
	end

	always_ff @(posedge clk) begin
		if (enc_we)
			enc_mem[enc_wa] <= enc_wd;
		enc_rd_q <= enc_mem[enc_ra];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			pos_q        <= '0;
			v_q          <= '0;
			walk_v_q     <= '0;
			hs_q         <= '0;
			ls_q         <= '0;
			walk_s1      <= 1'b0;
			fill_s1      <= 1'b0;
			idx_s1       <= '0;
			strobe_q     <= 1'b0;
			build_done_q <= 1'b0;
			last_q       <= 1'b0;
			sel_enc_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			walk_s1  <= (state_q == ST_WALK);
			fill_s1  <= (state_q == ST_ENC_FILL);
			idx_s1   <= cnt_q;
			if (walk_s1 && walk_ok)
				pos_q <= pos_q + BW'(1);
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						case (command)
							kbsc_pkg::CMD_BUILD: begin
								cnt_q    <= '0;
								pos_q    <= BW'(1);
								v_q      <= '0;
								walk_v_q <= '0;
								case (mode_q)
									kbsc_pkg::MODE_NONE: state_q <= ST_DEC_ID;
									kbsc_pkg::MODE_STATIC: begin
										cnt_q   <= AW'(1);
										state_q <= ST_DEC_STATIC;
									end
									kbsc_pkg::MODE_KEYED:
										state_q <= (key_q == '0) ? ST_DEC_ID : ST_KEY;
									default: state_q <= ST_ENC_CLR;
								endcase
							end
							kbsc_pkg::CMD_DECRYPT, kbsc_pkg::CMD_ENCRYPT: begin
								strobe_q     <= 1'b1;
								build_done_q <= 1'b0;
								last_q       <= last_in;
								sel_enc_q    <= (command == kbsc_pkg::CMD_ENCRYPT);
							end
							default: ;
						endcase
					end
				end
				ST_KEY: begin
					if (kp_res.done)
						state_q <= ST_GRID;
				end
				ST_DEC_ID: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_ENC_CLR;
				end
				ST_DEC_STATIC: begin
					cnt_q <= cnt_q + AW'(1);
					v_q   <= static_v;
					if (cnt_q == kbsc_pkg::STATIC_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_ENDS;
					end
				end
				ST_GRID: begin
					cnt_q <= cnt_q + AW'(1);
					hs_q  <= hi_cur;
					ls_q  <= lo_cur;
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					cnt_q    <= cnt_q + AW'(1);
					walk_v_q <= walk_addr;
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_WALK_DRAIN;
				end
				ST_WALK_DRAIN: begin
					cnt_q   <= '0;
					state_q <= ST_ENDS;
				end
				ST_ENDS: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q[0]) begin
						cnt_q   <= '0;
						state_q <= ST_ENC_CLR;
					end
				end
				ST_ENC_CLR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_ENC_FILL;
				end
				ST_ENC_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == kbsc_pkg::BYTE_TOP)
						state_q <= ST_ENC_DRAIN;
				end
				ST_ENC_DRAIN: begin
					strobe_q     <= 1'b1;
					build_done_q <= 1'b1;
					last_q       <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Outputs
	// ------------------------------------------------------------------
	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign build_done = build_done_q;
	assign last_out   = last_q;
	assign data_out   = build_done_q ? kbsc_pkg::BYTE_ZERO
		: (sel_enc_q ? enc_rd_q : dec_rd_q);

endmodule

`default_nettype wire

@@ rtl/core/kbsc_checker.sv @@
// ----------------------------------------------------------------------------
// kbsc_checker
// Port-level checks of the cipher unit's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_byte_substitution_cipher_unit_macros.svh"

module kbsc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic [kbsc_pkg::CMD_W-1:0]        command,
	input wire logic                              last_in,
	input wire logic                              strobe,
	input wire logic [kbsc_pkg::BYTE_W-1:0]       data_out,
	input wire logic                              last_out,
	input wire logic                              build_done
);

	logic byte_xfer;
	logic build_xfer;

	assign byte_xfer  = start && !busy && (command == kbsc_pkg::CMD_DECRYPT
		|| command == kbsc_pkg::CMD_ENCRYPT);
	assign build_xfer = start && !busy && (command == kbsc_pkg::CMD_BUILD);

	// byte lookup answers in the next cycle with its last mark
	`KBSC_ASSERT(a_byte_result, clk, arst_n, byte_xfer |=> strobe && !build_done && last_out == $past(last_in), "byte command result missing or wrong")

	// a build occupies the unit and gives no immediate result
	`KBSC_ASSERT(a_build_busy, clk, arst_n, build_xfer |=> busy && !strobe, "build did not hold busy")

	// idle without a transfer gives no result
	`KBSC_ASSERT(a_no_spurious, clk, arst_n, !busy && !start |=> !strobe, "result without command")

	// build result is zero data, right after the build sweep ends
	`KBSC_ASSERT(a_build_done, clk, arst_n, strobe && build_done |-> data_out == '0 && !last_out && !busy && $past(busy), "bad build result")

	// no result while a sweep is running
	`KBSC_NEVER(a_strobe_while_busy, clk, arst_n, strobe && busy, "result shown while busy")

endmodule

bind keyed_byte_substitution_cipher_unit kbsc_checker u_kbsc_checker (.*);

`default_nettype wire

@@ tb/sv/tb_keyed_byte_substitution_cipher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_byte_substitution_cipher_unit
// Self-checking bench for the keyed byte substitution cipher unit. A queue of
// commands and register writes feeds a clocked driver. Every command transfer
// is run through a local copy of the substitution tables. A clocked monitor
// compares each strobed result with the oldest predicted one.
// ----------------------------------------------------------------------------

module tb_keyed_byte_substitution_cipher_unit;
	import kbsc_pkg::*;

	// codes the package leaves unnamed: the block must ignore or tolerate them
	localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 8;          // quiet edges before a register write
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int IDLE_PCT      = 17;
	localparam int PHASES        = 11;
	localparam int PHASE_OPS     = 39;
	localparam int REPORT_CAP    = 40;

	typedef enum logic {OP_COMMAND, OP_CONFIG} op_kind_e;

	typedef struct {
		op_kind_e              kind;
		logic [CMD_W-1:0]      cmd;
		logic [BYTE_W-1:0]     data;
		logic                  last;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      wdata;
	} queued_op_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              build;
	} cipher_result_t;

	// ------------------------------------------------------------------------
	// DUT ports, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  busy;
	logic [CMD_W-1:0]      command    = CMD_BUILD;
	logic [BYTE_W-1:0]     data_in    = '0;
	logic                  last_in    = 1'b0;
	logic                  strobe;
	logic [BYTE_W-1:0]     data_out;
	logic                  last_out;
	logic                  build_done;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_MODE;
	logic [CFG_W-1:0]      cfg_wdata  = '0;

	keyed_byte_substitution_cipher_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.data_in    (data_in),
		.last_in    (last_in),
		.strobe     (strobe),
		.data_out   (data_out),
		.last_out   (last_out),
		.build_done (build_done),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Local copy of the cipher state
	// ------------------------------------------------------------------------
	logic [MODE_W-1:0] cur_mode;
	logic [KEY_W-1:0]  cur_key;
	logic [MOD_W-1:0]  cur_modifier;
	logic [BYTE_W-1:0] dec_map [TABLE_ENTRIES];
	logic [BYTE_W-1:0] enc_map [TABLE_ENTRIES];

	queued_op_t     queued_ops[$];    // stimulus not yet handed to the driver
	cipher_result_t results_due[$];   // predicted results, oldest first
	int             mismatches = 0;
	int             cycles     = 0;

	task automatic reset_cipher_state();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			dec_map[i] = BYTE_W'(i);
			enc_map[i] = BYTE_W'(i);
		end
		cur_mode     = MODE_NONE;
		cur_key      = '0;
		cur_modifier = '0;
	endtask

	task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		case (idx)
			REG_MODE:     cur_mode = value[MODE_W-1:0];
			REG_KEY:      cur_key = value;
			REG_MODIFIER: cur_modifier = value[MOD_W-1:0];
			default:      ;  // spare index writes nothing
		endcase
	endtask

	task automatic fill_identity();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			dec_map[i] = BYTE_W'(i);
	endtask

	// byte LCG, stepping over 0x00 and 0xFF once
	task automatic fill_static();
		logic [BYTE_W-1:0] v;
		v = '0;
		for (int i = 1; i < TABLE_ENTRIES - 1; i++) begin
			v = v * LCG_MUL + LCG_ADD;
			if (v == BYTE_ZERO || v == BYTE_TOP)
				v = v * LCG_MUL + LCG_ADD;
			dec_map[i] = v;
		end
		dec_map[0]                 = BYTE_ZERO;
		dec_map[TABLE_ENTRIES - 1] = BYTE_TOP;
	endtask

	// 16 steps of the seeded 4-bit LCG; seed high nibble is the start value
	function automatic logic [15:0][3:0] nibble_run(input logic [BYTE_W-1:0] seed);
		logic [3:0]       mul;
		logic [3:0]       inc;
		logic [3:0]       s;
		logic [15:0][3:0] seq;
		mul = {seed[0], 3'b101};
		inc = {seed[3:1], 1'b1};
		s   = seed[7:4];
		for (int i = 0; i < 16; i++) begin
			s      = s * mul + inc;
			seq[i] = s;
		end
		return seq;
	endfunction

	task automatic fill_keyed(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0]  k;
		logic [BYTE_W-1:0] kb [7];
		logic [BYTE_W-1:0] mix [16];
		logic [15:0][3:0]  hi_run;
		logic [15:0][3:0]  lo_run;
		logic [BYTE_W-1:0] grid [TABLE_ENTRIES];
		logic [BYTE_W-1:0] walk;
		logic [BYTE_W-1:0] cand;
		int                pos;
		k = key - 1'b1;  // zero wraps to all ones
		for (int i = 0; i < 7; i++)
			kb[i] = k[8*i +: 8];
		mix[0]  = kb[1];         mix[1]  = kb[1] ^ kb[6];
		mix[2]  = kb[2] ^ kb[3]; mix[3]  = kb[2];
		mix[4]  = kb[2] ^ kb[1]; mix[5]  = kb[3] ^ kb[4];
		mix[6]  = kb[3];         mix[7]  = kb[3] ^ kb[2];
		mix[8]  = kb[4] ^ kb[5]; mix[9]  = kb[4];
		mix[10] = kb[4] ^ kb[3]; mix[11] = kb[5] ^ kb[6];
		mix[12] = kb[5];         mix[13] = kb[5] ^ kb[4];
		mix[14] = kb[6] ^ kb[1]; mix[15] = kb[6];
		hi_run = nibble_run(kb[0]);
		for (int i = 0; i < 16; i++) begin
			lo_run = nibble_run(mix[i]);
			for (int j = 0; j < 16; j++)
				grid[i*16 + j] = {hi_run[i], lo_run[j]};
		end
		// walk the grid with step 0x11; entries past the last fill keep old values
		pos  = 1;
		walk = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			walk = walk + WALK_STEP;
			cand = grid[walk];
			if (cand != BYTE_ZERO && cand != BYTE_TOP && pos < TABLE_ENTRIES - 1) begin
				dec_map[pos] = cand;
				pos++;
			end
		end
		dec_map[0]                 = BYTE_ZERO;
		dec_map[TABLE_ENTRIES - 1] = BYTE_TOP;
	endtask

	task automatic rebuild_maps();
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] factor;
		k = cur_key;
		case (cur_mode)
			MODE_NONE:   fill_identity();
			MODE_STATIC: fill_static();
			MODE_KEYED: begin
				if (k == '0) begin
					fill_identity();
				end else begin
					if (cur_modifier != '0) begin
						factor = {32'd0, cur_modifier, 16'(~cur_modifier + 16'd2)};
						k      = k * factor;
					end
					fill_keyed(k);
				end
			end
			default: ;  // spare mode: decrypt table untouched
		endcase
		// inverse is always rebuilt, starting from all zero
		for (int i = 0; i < TABLE_ENTRIES; i++)
			enc_map[i] = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			enc_map[dec_map[i]] = BYTE_W'(i);
	endtask

	// result of one command transfer, queued for the monitor
	task automatic predict_cipher(input logic [CMD_W-1:0] cmd,
		input logic [BYTE_W-1:0] data, input logic last);
		cipher_result_t r;
		case (cmd)
			CMD_BUILD: begin
				rebuild_maps();
				r = '{data: BYTE_ZERO, last: 1'b0, build: 1'b1};
				results_due.push_back(r);
			end
			CMD_DECRYPT: begin
				r = '{data: dec_map[data], last: last, build: 1'b0};
				results_due.push_back(r);
			end
			CMD_ENCRYPT: begin
				r = '{data: enc_map[data], last: last, build: 1'b0};
				results_due.push_back(r);
			end
			default: ;  // dropped without a result
		endcase
	endtask

	task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
		input logic last);
		queued_op_t op;
		op = '{kind: OP_COMMAND, cmd: cmd, data: data, last: last, idx: REG_MODE,
			wdata: '0};
		queued_ops.push_back(op);
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] wdata);
		queued_op_t op;
		op = '{kind: OP_CONFIG, cmd: CMD_BUILD, data: '0, last: 1'b0, idx: idx,
			wdata: wdata};
		queued_ops.push_back(op);
	endtask

	task automatic check_field(input string what, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: samples the handshake at the edge, then picks what to drive next.
	// Each port gets one nonblocking update per edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : driver
		logic       go;
		logic       we_next;
		logic       idle_now;
		queued_op_t head;
		int         quiet;      // edges since the last command transfer
		int         transfers;
		if (arst_n) begin
			if (cfg_we)
				apply_config(cfg_index, cfg_wdata);
			go      = start;
			we_next = 1'b0;
			if (start && !busy) begin
				predict_cipher(command, data_in, last_in);
				transfers++;
				quiet = 0;
				go    = 1'b0;
			end else if (quiet < SETTLE_CYCLES) begin
				quiet++;
			end
			// random idling, except for one stretch of back-to-back transfers
			idle_now = ($urandom_range(0, 99) < IDLE_PCT) &&
				!(transfers >= 200 && transfers < 300);
			if (!go && !idle_now && queued_ops.size() != 0) begin
				head = queued_ops[0];
				if (head.kind == OP_CONFIG) begin
					// registers change only once the block has drained and settled;
					// no strobe now, so the monitor is not popping this edge
					if (results_due.size() == 0 && strobe !== 1'b1 &&
						quiet >= SETTLE_CYCLES) begin
						we_next   = 1'b1;
						cfg_index <= head.idx;
						cfg_wdata <= head.wdata;
						void'(queued_ops.pop_front());
					end
				end else begin
					go      = 1'b1;
					command <= head.cmd;
					data_in <= head.data;
					last_in <= head.last;
					void'(queued_ops.pop_front());
				end
			end
			start  <= go;
			cfg_we <= we_next;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: the receiver cannot stall, every strobe is a result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		cipher_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: result expected none actual data_out %0h last_out %0b build_done %0b",
						$time, data_out, last_out, build_done);
			end else begin
				want = results_due.pop_front();
				check_field("data_out", want.data, data_out);
				check_field("last_out", BYTE_W'(want.last), BYTE_W'(last_out));
				check_field("build_done", BYTE_W'(want.build), BYTE_W'(build_done));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("keyed_byte_substitution_cipher_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int                sel;
		logic [CFG_W-1:0]  wd;
		logic [CMD_W-1:0]  cmd;
		reset_cipher_state();

		// tables come out of reset as identity
		push_cmd(CMD_DECRYPT, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, BYTE_TOP, 1'b1);
		push_cmd(CMD_ENCRYPT, 8'h5A, 1'b0);

		// static table; build ignores the byte and the last mark
		push_cfg(REG_MODE, CFG_W'(MODE_STATIC));
		push_cmd(CMD_BUILD, BYTE_TOP, 1'b1);
		push_cmd(CMD_DECRYPT, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, 8'h01, 1'b0);
		push_cmd(CMD_DECRYPT, BYTE_TOP, 1'b0);
		push_cmd(CMD_ENCRYPT, 8'h80, 1'b1);

		// keyed mode with a zero key falls back to identity
		push_cfg(REG_MODE, CFG_W'(MODE_KEYED));
		push_cfg(REG_KEY, '0);
		push_cfg(REG_MODIFIER, '0);
		push_cmd(CMD_BUILD, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, 8'hA5, 1'b0);

		// key and modifier at their top values
		push_cfg(REG_KEY, '1);
		push_cfg(REG_MODIFIER, CFG_W'(16'hFFFF));
		push_cmd(CMD_BUILD, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, 8'h01, 1'b0);
		push_cmd(CMD_ENCRYPT, 8'hFE, 1'b1);

		// 2^48 times 0x10000 scrambles to zero, decrement wraps to all ones
		push_cfg(REG_KEY, 64'h0001_0000_0000_0000);
		push_cfg(REG_MODIFIER, CFG_W'(16'h0001));
		push_cmd(CMD_BUILD, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, 8'h7F, 1'b0);

		// spare index is ignored; spare mode keeps the decrypt table
		push_cfg(REG_SPARE, '1);
		push_cfg(REG_MODE, CFG_W'(MODE_SPARE));
		push_cmd(CMD_BUILD, BYTE_ZERO, 1'b0);
		push_cmd(CMD_ENCRYPT, 8'h33, 1'b0);
		push_cmd(CMD_DECRYPT, 8'h33, 1'b1);
		push_cmd(CMD_NONE, 8'h12, 1'b1);  // dropped, no result

		push_cfg(REG_MODE, CFG_W'(MODE_NONE));
		push_cmd(CMD_BUILD, BYTE_ZERO, 1'b0);
		push_cmd(CMD_DECRYPT, 8'h42, 1'b0);

		// random phases: new settings, a build, then a stream of lookups
		for (int ph = 0; ph < PHASES; ph++) begin
			sel = $urandom_range(0, 9);
			wd  = {$urandom(), $urandom()};
			wd[MODE_W-1:0] = (sel == 0) ? MODE_NONE :
				(sel < 3) ? MODE_STATIC :
				(sel < 9) ? MODE_KEYED : MODE_SPARE;
			push_cfg(REG_MODE, wd);

			sel = $urandom_range(0, 9);
			case (sel)
				0:       wd = '0;
				1:       wd = '1;
				2:       wd = CFG_W'($urandom_range(1, 255));
				default: wd = {$urandom(), $urandom()};
			endcase
			push_cfg(REG_KEY, wd);

			sel = $urandom_range(0, 9);
			wd  = {$urandom(), $urandom()};
			if (sel < 3)
				wd[MOD_W-1:0] = '0;
			else if (sel == 3)
				wd[MOD_W-1:0] = '1;
			else if (sel == 4)
				wd[MOD_W-1:0] = 16'h0001;
			push_cfg(REG_MODIFIER, wd);

			push_cmd(CMD_BUILD, BYTE_W'($urandom()), 1'($urandom()));
			for (int n = 0; n < PHASE_OPS; n++) begin
				sel = $urandom_range(0, 99);
				cmd = (sel < 2) ? CMD_BUILD :
					(sel < 4) ? CMD_NONE :
					(sel < 52) ? CMD_DECRYPT : CMD_ENCRYPT;
				push_cmd(cmd, BYTE_W'($urandom()), $urandom_range(0, 7) == 0);
			end
			if ($urandom_range(0, 3) == 0)
				push_cfg(REG_SPARE, {$urandom(), $urandom()});
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// checks at the falling edge see settled queues and ports
		while (queued_ops.size() != 0 || start || cfg_we || results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("keyed_byte_substitution_cipher_unit: match");
		else
			$display("keyed_byte_substitution_cipher_unit: mismatch");
		$finish;
	end

endmodule
